/* rtl/multi_click_command_qualifier_assert.svh */
// Assertion macros for the multi-click command qualifier checker
`ifndef MULTI_CLICK_COMMAND_QUALIFIER_ASSERT_SVH
`define MULTI_CLICK_COMMAND_QUALIFIER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MCCQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mccq assertion failed");

// next-cycle implication, disabled in reset
`define MCCQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mccq assertion failed");

`endif

/* rtl/mccq_pkg.sv */
// Shared types and constants for the multi-click command qualifier
package mccq_pkg;

  localparam int CNT_W      = 8;
  localparam int TMR_W      = 16;
  localparam int HOUR_W     = 5;
  localparam int CMD_W      = 2;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_OTHER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

  localparam logic [ACT_W-1:0] ACT_CLICK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_WIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_WIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_NORM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_NORM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_START  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_END    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd7;

  localparam logic [CNT_W-1:0]  CLICKS_RST    = 8'd1;
  localparam logic [HOUR_W-1:0] WIN_START_RST = 5'd22;
  localparam logic [HOUR_W-1:0] WIN_END_RST   = 5'd6;
  localparam logic [TMR_W-1:0]  TIMEOUT_RST   = 16'd500;
  localparam logic [CNT_W-1:0]  COUNT_MAX     = 8'd255;

  typedef struct packed {
    logic [CNT_W-1:0]  open_win;
    logic [CNT_W-1:0]  close_win;
    logic [CNT_W-1:0]  open_norm;
    logic [CNT_W-1:0]  close_norm;
    logic              time_mode;
    logic [HOUR_W-1:0] win_start;
    logic [HOUR_W-1:0] win_end;
    logic [TMR_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [CMD_W-1:0]  cmd;
    logic [HOUR_W-1:0] hour;
    logic              clk_valid;
  } item_t;

  typedef struct packed {
    logic             run_now;
    logic             dispatched;
    logic             ignored;
    logic [CMD_W-1:0] dcmd;
  } res_t;

endpackage

/* rtl/mccq_cfg_regs.sv */
// Configuration register file for the multi-click command qualifier
module mccq_cfg_regs
  import mccq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_win   <= CLICKS_RST;
      cfg_r.close_win  <= CLICKS_RST;
      cfg_r.open_norm  <= CLICKS_RST;
      cfg_r.close_norm <= CLICKS_RST;
      cfg_r.time_mode  <= 1'b0;
      cfg_r.win_start  <= WIN_START_RST;
      cfg_r.win_end    <= WIN_END_RST;
      cfg_r.timeout    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OPEN_WIN:   cfg_r.open_win   <= cfg_wdata[CNT_W-1:0];
        REG_CLOSE_WIN:  cfg_r.close_win  <= cfg_wdata[CNT_W-1:0];
        REG_OPEN_NORM:  cfg_r.open_norm  <= cfg_wdata[CNT_W-1:0];
        REG_CLOSE_NORM: cfg_r.close_norm <= cfg_wdata[CNT_W-1:0];
        REG_TIME_MODE:  cfg_r.time_mode  <= cfg_wdata[0];
        REG_WIN_START:  cfg_r.win_start  <= cfg_wdata[HOUR_W-1:0];
        REG_WIN_END:    cfg_r.win_end    <= cfg_wdata[HOUR_W-1:0];
        REG_TIMEOUT:    cfg_r.timeout    <= cfg_wdata[TMR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/mccq_qualify.sv */
// Click counting, timeout and dispatch decision state
module mccq_qualify
  import mccq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [CMD_W-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TMR_W-1:0] tmr_r, tmr_nxt;
  logic             run_r, run_nxt;

  logic [CMD_W-1:0] cmd_n;
  logic [CNT_W-1:0] req_click, req_tick, cnt_base;

  function automatic logic [CNT_W-1:0] req_f(cfg_t c, logic [CMD_W-1:0] cmd,
                                             logic [HOUR_W-1:0] hour, logic vld);
    logic [CNT_W-1:0] in_win, norm;
    logic             in_hours;
    in_win = CLICKS_RST;
    norm   = CLICKS_RST;
    if (cmd == CMD_OPEN) begin
      in_win = c.open_win;
      norm   = c.open_norm;
    end else if (cmd == CMD_CLOSE) begin
      in_win = c.close_win;
      norm   = c.close_norm;
    end
    if (c.win_start < c.win_end)
      in_hours = (hour >= c.win_start) && (hour < c.win_end);
    else
      in_hours = (hour >= c.win_start) || (hour < c.win_end);
    return (!c.time_mode || !vld || in_hours) ? in_win : norm;
  endfunction

  always_comb begin
    cmd_n     = (item.cmd == CMD_RSVD) ? CMD_OTHER : item.cmd;
    req_click = req_f(cfg, cmd_n, item.hour, item.clk_valid);
    req_tick  = req_f(cfg, pend_r, item.hour, item.clk_valid);
    cnt_base  = (cmd_n != pend_r) ? '0 : cnt_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    tmr_nxt   = tmr_r;
    run_nxt   = run_r;
    res       = '0;
    case (item.action)
      ACT_CLICK: begin
        if (req_click == CNT_W'(1)) begin
          res.run_now = 1'b1;
        end else begin
          pend_nxt = cmd_n;
          cnt_nxt  = (cnt_base != COUNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;
          tmr_nxt  = cfg.timeout;
          run_nxt  = 1'b1;
        end
      end
      ACT_TICK: begin
        if (run_r) begin
          if (tmr_r <= TMR_W'(1)) begin
            res.dcmd       = pend_r;
            res.dispatched = (cnt_r >= req_tick);
            res.ignored    = (cnt_r < req_tick);
            pend_nxt       = CMD_OTHER;
            cnt_nxt        = '0;
            tmr_nxt        = '0;
            run_nxt        = 1'b0;
          end else begin
            tmr_nxt = tmr_r - TMR_W'(1);
          end
        end
      end
      ACT_CLEAR: begin
        cnt_nxt = '0;
        tmr_nxt = '0;
        run_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= CMD_OTHER;
      cnt_r  <= '0;
      tmr_r  <= '0;
      run_r  <= 1'b0;
    end else if (step) begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      tmr_r  <= tmr_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule

/* rtl/multi_click_command_qualifier.sv */
// Top level of the multi-click command qualifier
//
//   channel | dir | handshake          | contents
//   in_     | in  | in_tvalid/tready   | tuser action, tdata command/hour/clock valid
//   out_    | out | out_tvalid/tready  | tdata run/dispatch/ignore flags and command
//   cfg_    | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// One word in, one word out, one word per cycle sustained while out_tready is high.
// A word passes through the input register, then decision logic into the output register.
// The click and timer state advance as a word leaves the input register.
// A stalled output holds its word; the input register still takes a word while it is empty.
// rst_n is synchronous; after reset all required click counts are 1 and the timer is stopped.
module multi_click_command_qualifier
  import mccq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // command_code[1:0], current_hour[6:2], clock_valid[7]
  input  logic [ACT_W-1:0]      in_tuser,   // action[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // run_now[0], dispatched[1], ignored[2],
                                            // dispatched_command[4:3], zero[7:5]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item_r;
  res_t  res, res_r;
  logic  in_vld_r, out_vld_r;
  logic  adv, step;

  assign adv       = !out_vld_r || out_tready;
  assign step      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  mccq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mccq_qualify u_qual (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        in_vld_r <= 1'b1;
      else if (step)
        in_vld_r <= 1'b0;
      if (adv)
        out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action    <= in_tuser;
      item_r.cmd       <= in_tdata[1:0];
      item_r.hour      <= in_tdata[6:2];
      item_r.clk_valid <= in_tdata[7];
    end
    if (step)
      res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res_r.dcmd, res_r.ignored, res_r.dispatched, res_r.run_now};

endmodule

/* rtl/mccq_checker.sv */
// Port-level checker for the multi-click command qualifier, with its bind
`include "multi_click_command_qualifier_assert.svh"

module mccq_port_checker
  import mccq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [CMD_W-1:0] dcmd;
  logic             expiry;

  assign dcmd   = out_tdata[4:3];
  assign expiry = out_tdata[1] || out_tdata[2];

  `MCCQ_ASSERT_IMP(a_one_outcome, clk, rst_n, out_tvalid, $countones(out_tdata[2:0]) <= 1)
  `MCCQ_ASSERT_IMP(a_run_no_cmd, clk, rst_n, out_tvalid && out_tdata[0], dcmd == CMD_OTHER)
  `MCCQ_ASSERT_IMP(a_expiry_cmd, clk, rst_n, out_tvalid && expiry, dcmd[0] != dcmd[1])
  `MCCQ_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind multi_click_command_qualifier mccq_port_checker u_mccq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
